// ===== hw/rtl/lpcp_pkg.sv =====
// Shared constants and types for the line pair closest point block.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lpcp_pkg;

    localparam int COORD_WIDTH_DEFAULT = 32;

    // Operand slice handled by one hardware multiplier per pipeline stage
    localparam int MUL_CHUNK = 32;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_PARALLEL  = 2'd1;
    localparam status_t STATUS_SATURATED = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/lpcp_if.sv =====
// Valid/ready channel interfaces: line pair transactions in, closest point out.
// Depends on lpcp_pkg for the default coordinate width and the status type.
`timescale 1ns / 1ps
`default_nettype none

interface lpcp_line_if import lpcp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_start_x;
    logic signed [COORD_WIDTH-1:0] first_start_y;
    logic signed [COORD_WIDTH-1:0] first_start_z;
    logic signed [COORD_WIDTH-1:0] first_dir_x;
    logic signed [COORD_WIDTH-1:0] first_dir_y;
    logic signed [COORD_WIDTH-1:0] first_dir_z;
    logic signed [COORD_WIDTH-1:0] second_start_x;
    logic signed [COORD_WIDTH-1:0] second_start_y;
    logic signed [COORD_WIDTH-1:0] second_start_z;
    logic signed [COORD_WIDTH-1:0] second_dir_x;
    logic signed [COORD_WIDTH-1:0] second_dir_y;
    logic signed [COORD_WIDTH-1:0] second_dir_z;

    modport source (
        output valid, first_start_x, first_start_y, first_start_z,
               first_dir_x, first_dir_y, first_dir_z,
               second_start_x, second_start_y, second_start_z,
               second_dir_x, second_dir_y, second_dir_z,
        input  ready
    );

    modport sink (
        input  valid, first_start_x, first_start_y, first_start_z,
               first_dir_x, first_dir_y, first_dir_z,
               second_start_x, second_start_y, second_start_z,
               second_dir_x, second_dir_y, second_dir_z,
        output ready
    );
endinterface

interface lpcp_point_if import lpcp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    status_t                       result_status;

    modport source (
        output valid, point_x, point_y, point_z, result_status,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, point_z, result_status,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/lpcp_mul.sv =====
// Pipelined signed multiplier: one MUL_CHUNK slice of a per stage, accumulated.
// Carries a valid bit and a side bundle with the same latency. Uses lpcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpcp_mul import lpcp_pkg::*; #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int SW = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ce,
    input  logic                 in_vld,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    input  logic [SW-1:0]        side_in,
    output logic                 out_vld,
    output logic signed [AW+BW-1:0] p,
    output logic [SW-1:0]        side_out
);

    localparam int NCH = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int AXW = NCH * MUL_CHUNK;
    localparam int PW  = AW + BW;
    localparam int PRW = MUL_CHUNK + 1 + BW;
    localparam int LAT = NCH + 2;

    logic signed [AXW-1:0] a_reg    [NCH];
    logic signed [BW-1:0]  b_reg    [NCH];
    logic signed [PRW-1:0] prod_reg [NCH];
    logic signed [PW-1:0]  acc_reg  [NCH];
    logic                  vld_reg  [LAT];
    logic [SW-1:0]         side_reg [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (ce)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k < LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_reg[0]    <= AXW'(a);
            b_reg[0]    <= b;
            side_reg[0] <= side_in;
            for (int k = 1; k < NCH; k++)
            begin
                a_reg[k] <= a_reg[k-1];
                b_reg[k] <= b_reg[k-1];
            end
            for (int k = 1; k < LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    for (genvar k = 0; k < NCH; k++)
    begin : g_chunk
        logic signed [MUL_CHUNK:0] ch;

        // Lower slices are unsigned, the top slice holds the sign
        if (k == NCH - 1)
        begin : g_top
            assign ch = (MUL_CHUNK+1)'($signed(a_reg[k][k*MUL_CHUNK +: MUL_CHUNK]));
        end
        else
        begin : g_low
            assign ch = {1'b0, a_reg[k][k*MUL_CHUNK +: MUL_CHUNK]};
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                prod_reg[k] <= ch * b_reg[k];
            end
        end

        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    acc_reg[0] <= PW'(prod_reg[0]);
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    acc_reg[k] <= acc_reg[k-1] + (PW'(prod_reg[k]) <<< (k*MUL_CHUNK));
                end
            end
        end
    end

    assign p        = acc_reg[NCH-1];
    assign out_vld  = vld_reg[LAT-1];
    assign side_out = side_reg[LAT-1];

endmodule

`default_nettype wire

// ===== hw/rtl/line_pair_closest_point.sv =====
// Closest point on the first of two 3D lines to the second, exact integer datapath.
// Four sliced multiply phases feed the magnitude register, a restoring divider,
// the rounding register and the output register.
// Throughput: one transaction per cycle; the shared clock enable holds every stage
// while the output register is full and not taken. Reset clears only valid bits.
// Depends on lpcp_pkg, lpcp_if (channels) and lpcp_mul (sliced multipliers).
`timescale 1ns / 1ps
`default_nettype none

module line_pair_closest_point import lpcp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    lpcp_line_if.sink    lines,
    lpcp_point_if.source result
);

    localparam int W    = COORD_WIDTH;
    localparam int WW   = W + 1;
    localparam int NW   = 2*W + 1;
    localparam int MW   = 3*W + 2;
    localparam int NUMW = 4*W + 5;
    localparam int DENW = 4*W + 4;
    localparam int PW   = 5*W + 5;
    localparam int QB   = W + 2;
    localparam int RW   = PW + 1;
    localparam int SUMW = QB + 3;

    localparam logic signed [W-1:0] MAX_C = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_C = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [2:0][W-1:0]  s1;
        logic [2:0][W-1:0]  d1;
        logic [2:0][W-1:0]  d2;
        logic [2:0][WW-1:0] w;
    } p1_side_t;

    typedef struct packed {
        logic [2:0][W-1:0]  s1;
        logic [2:0][W-1:0]  d1;
        logic [2:0][WW-1:0] w;
    } p2_side_t;

    typedef struct packed {
        logic [2:0][W-1:0] s1;
        logic [2:0][W-1:0] d1;
    } p3_side_t;

    typedef struct packed {
        logic [2:0][W-1:0] s1;
        logic [DENW-1:0]   den;
    } p4_side_t;

    typedef struct packed {
        logic [2:0][PW-1:0] ma;
        logic [DENW-1:0]    mb;
        logic [2:0]         neg;
        logic               zero;
        logic [2:0][W-1:0]  s1;
    } mag_t;

    typedef struct packed {
        logic [2:0][PW-1:0] r;
        logic [2:0][QB-1:0] q;
        logic [DENW-1:0]    mb;
        logic [2:0]         neg;
        logic [2:0]         ovf;
        logic               zero;
        logic [2:0][W-1:0]  s1;
    } div_t;

    typedef struct packed {
        logic [2:0][QB+1:0] qs;
        logic [2:0]         neg;
        logic [2:0]         ovf;
        logic               zero;
        logic [2:0][W-1:0]  s1;
    } rnd_t;

    logic ce;

    p1_side_t side0, side1;
    p2_side_t side2;
    p3_side_t side3;
    p4_side_t side4_in, side4;
    logic     vld1, vld2, vld3, vld4;

    logic signed [W-1:0]     d1_in [3];
    logic signed [W-1:0]     d2_in [3];
    logic signed [2*W-1:0]   p1_pos [3];
    logic signed [2*W-1:0]   p1_neg [3];
    logic signed [NW-1:0]    n_vec [3];
    logic signed [3*W:0]     p2_pos [3];
    logic signed [3*W:0]     p2_neg [3];
    logic signed [MW-1:0]    m_vec [3];
    logic signed [MW+WW-1:0] p3_mw [3];
    logic signed [MW+W-1:0]  p3_md [3];
    logic signed [NUMW-1:0]  num;
    logic signed [DENW-1:0]  den;
    logic signed [PW-1:0]    p4 [3];

    mag_t mag_reg, mag_next;
    logic mag_vld_reg;
    div_t div_reg [QB+1];
    div_t div_first;
    logic div_vld_reg [QB+1];
    rnd_t rnd_reg, rnd_next;
    logic rnd_vld_reg;

    logic [W-1:0] point_reg [3];
    logic [W-1:0] point_next [3];
    status_t      status_reg, status_next;
    logic         out_vld_reg;

    // Hold the whole pipeline while a finished result waits at the output
    assign ce          = !out_vld_reg || result.ready;
    assign lines.ready = ce;

    always_comb
    begin
        side0.s1[0] = lines.first_start_x;
        side0.s1[1] = lines.first_start_y;
        side0.s1[2] = lines.first_start_z;
        side0.d1[0] = lines.first_dir_x;
        side0.d1[1] = lines.first_dir_y;
        side0.d1[2] = lines.first_dir_z;
        side0.d2[0] = lines.second_dir_x;
        side0.d2[1] = lines.second_dir_y;
        side0.d2[2] = lines.second_dir_z;
        side0.w[0]  = WW'(lines.second_start_x) - WW'(lines.first_start_x);
        side0.w[1]  = WW'(lines.second_start_y) - WW'(lines.first_start_y);
        side0.w[2]  = WW'(lines.second_start_z) - WW'(lines.first_start_z);
        d1_in[0]    = lines.first_dir_x;
        d1_in[1]    = lines.first_dir_y;
        d1_in[2]    = lines.first_dir_z;
        d2_in[0]    = lines.second_dir_x;
        d2_in[1]    = lines.second_dir_y;
        d2_in[2]    = lines.second_dir_z;
    end

    // n = d1 x d2
    for (genvar i = 0; i < 3; i++)
    begin : g_cross1
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        if (i == 0)
        begin : g_carry
            lpcp_mul #(.AW(W), .BW(W), .SW($bits(p1_side_t))) u_pos (
                .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(lines.valid),
                .a(d1_in[J]), .b(d2_in[K]), .side_in(side0),
                .out_vld(vld1), .p(p1_pos[i]), .side_out(side1)
            );
        end
        else
        begin : g_plain
            lpcp_mul #(.AW(W), .BW(W), .SW(1)) u_pos (
                .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(lines.valid),
                .a(d1_in[J]), .b(d2_in[K]), .side_in(1'b0),
                .out_vld(), .p(p1_pos[i]), .side_out()
            );
        end

        lpcp_mul #(.AW(W), .BW(W), .SW(1)) u_neg (
            .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(lines.valid),
            .a(d1_in[K]), .b(d2_in[J]), .side_in(1'b0),
            .out_vld(), .p(p1_neg[i]), .side_out()
        );

        assign n_vec[i] = NW'(p1_pos[i]) - NW'(p1_neg[i]);
    end

    // m = n x d2
    for (genvar i = 0; i < 3; i++)
    begin : g_cross2
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        if (i == 0)
        begin : g_carry
            lpcp_mul #(.AW(NW), .BW(W), .SW($bits(p2_side_t))) u_pos (
                .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(vld1),
                .a(n_vec[J]), .b($signed(side1.d2[K])),
                .side_in({side1.s1, side1.d1, side1.w}),
                .out_vld(vld2), .p(p2_pos[i]), .side_out(side2)
            );
        end
        else
        begin : g_plain
            lpcp_mul #(.AW(NW), .BW(W), .SW(1)) u_pos (
                .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(vld1),
                .a(n_vec[J]), .b($signed(side1.d2[K])), .side_in(1'b0),
                .out_vld(), .p(p2_pos[i]), .side_out()
            );
        end

        lpcp_mul #(.AW(NW), .BW(W), .SW(1)) u_neg (
            .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(vld1),
            .a(n_vec[K]), .b($signed(side1.d2[J])), .side_in(1'b0),
            .out_vld(), .p(p2_neg[i]), .side_out()
        );

        assign m_vec[i] = MW'(p2_pos[i]) - MW'(p2_neg[i]);
    end

    // Terms of m.(s2 - s1) and m.d1
    for (genvar i = 0; i < 3; i++)
    begin : g_dot
        if (i == 0)
        begin : g_carry
            lpcp_mul #(.AW(MW), .BW(WW), .SW($bits(p3_side_t))) u_mw (
                .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(vld2),
                .a(m_vec[i]), .b($signed(side2.w[i])),
                .side_in({side2.s1, side2.d1}),
                .out_vld(vld3), .p(p3_mw[i]), .side_out(side3)
            );
        end
        else
        begin : g_plain
            lpcp_mul #(.AW(MW), .BW(WW), .SW(1)) u_mw (
                .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(vld2),
                .a(m_vec[i]), .b($signed(side2.w[i])), .side_in(1'b0),
                .out_vld(), .p(p3_mw[i]), .side_out()
            );
        end

        lpcp_mul #(.AW(MW), .BW(W), .SW(1)) u_md (
            .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(vld2),
            .a(m_vec[i]), .b($signed(side2.d1[i])), .side_in(1'b0),
            .out_vld(), .p(p3_md[i]), .side_out()
        );
    end

    assign num = NUMW'(p3_mw[0]) + NUMW'(p3_mw[1]) + NUMW'(p3_mw[2]);
    assign den = DENW'(p3_md[0]) + DENW'(p3_md[1]) + DENW'(p3_md[2]);

    assign side4_in.s1  = side3.s1;
    assign side4_in.den = den;

    // Dividends d1 * num, one per coordinate
    for (genvar i = 0; i < 3; i++)
    begin : g_scale
        if (i == 0)
        begin : g_carry
            lpcp_mul #(.AW(NUMW), .BW(W), .SW($bits(p4_side_t))) u_mul (
                .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(vld3),
                .a(num), .b($signed(side3.d1[i])), .side_in(side4_in),
                .out_vld(vld4), .p(p4[i]), .side_out(side4)
            );
        end
        else
        begin : g_plain
            lpcp_mul #(.AW(NUMW), .BW(W), .SW(1)) u_mul (
                .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(vld3),
                .a(num), .b($signed(side3.d1[i])), .side_in(1'b0),
                .out_vld(), .p(p4[i]), .side_out()
            );
        end
    end

    // Magnitudes and quotient signs
    always_comb
    begin
        mag_next.s1   = side4.s1;
        mag_next.zero = (side4.den == '0);
        mag_next.mb   = side4.den[DENW-1] ? (DENW'(0) - side4.den) : side4.den;
        for (int c = 0; c < 3; c++)
        begin
            mag_next.ma[c]  = p4[c][PW-1] ? (PW'(0) - PW'(p4[c])) : PW'(p4[c]);
            mag_next.neg[c] = p4[c][PW-1] ^ side4.den[DENW-1];
        end
    end

    // Quotients wider than QB bits saturate anyway; flag them up front
    always_comb
    begin
        div_first.r    = mag_reg.ma;
        div_first.q    = '0;
        div_first.mb   = mag_reg.mb;
        div_first.neg  = mag_reg.neg;
        div_first.zero = mag_reg.zero;
        div_first.s1   = mag_reg.s1;
        for (int c = 0; c < 3; c++)
        begin
            div_first.ovf[c] = RW'(mag_reg.ma[c]) >= (RW'(mag_reg.mb) << QB);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_vld_reg    <= 1'b0;
            div_vld_reg[0] <= 1'b0;
        end
        else if (ce)
        begin
            mag_vld_reg    <= vld4;
            div_vld_reg[0] <= mag_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mag_reg    <= mag_next;
            div_reg[0] <= div_first;
        end
    end

    // Restoring division, one quotient bit per stage, most significant first
    for (genvar t = 0; t < QB; t++)
    begin : g_div
        localparam int BIT = QB - 1 - t;

        logic [RW:0] diff [3];
        div_t        step_next;

        always_comb
        begin
            step_next = div_reg[t];
            for (int c = 0; c < 3; c++)
            begin
                diff[c] = {1'b0, RW'(div_reg[t].r[c])} - {1'b0, RW'(div_reg[t].mb) << BIT};
                if (!diff[c][RW])
                begin
                    step_next.r[c]      = diff[c][PW-1:0];
                    step_next.q[c][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_vld_reg[t+1] <= 1'b0;
            end
            else if (ce)
            begin
                div_vld_reg[t+1] <= div_vld_reg[t];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                div_reg[t+1] <= step_next;
            end
        end
    end

    // Round half away from zero on the magnitude, then apply the sign
    always_comb
    begin
        logic             rbit;
        logic [QB:0]      qm;
        rnd_next.neg  = div_reg[QB].neg;
        rnd_next.ovf  = div_reg[QB].ovf;
        rnd_next.zero = div_reg[QB].zero;
        rnd_next.s1   = div_reg[QB].s1;
        for (int c = 0; c < 3; c++)
        begin
            rbit = {div_reg[QB].r[c], 1'b0} >= (PW+1)'(div_reg[QB].mb);
            qm   = (QB+1)'(div_reg[QB].q[c]) + (QB+1)'(rbit);
            rnd_next.qs[c] = div_reg[QB].neg[c] ? ((QB+2)'(0) - (QB+2)'(qm))
                                                : (QB+2)'(qm);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            rnd_vld_reg <= div_vld_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rnd_reg <= rnd_next;
        end
    end

    // Add the start point, clamp, pick the status
    always_comb
    begin
        logic signed [SUMW-1:0] sum;
        logic                   sat;
        sat = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            sum = SUMW'($signed(rnd_reg.qs[c])) + SUMW'($signed(rnd_reg.s1[c]));
            if (rnd_reg.ovf[c])
            begin
                point_next[c] = rnd_reg.neg[c] ? MIN_C : MAX_C;
                sat           = 1'b1;
            end
            else if (sum > SUMW'(MAX_C))
            begin
                point_next[c] = MAX_C;
                sat           = 1'b1;
            end
            else if (sum < SUMW'(MIN_C))
            begin
                point_next[c] = MIN_C;
                sat           = 1'b1;
            end
            else
            begin
                point_next[c] = sum[W-1:0];
            end
        end
        if (rnd_reg.zero)
        begin
            for (int c = 0; c < 3; c++)
            begin
                point_next[c] = '0;
            end
            status_next = STATUS_PARALLEL;
        end
        else if (sat)
        begin
            status_next = STATUS_SATURATED;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_vld_reg <= rnd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            point_reg  <= point_next;
            status_reg <= status_next;
        end
    end

    assign result.valid         = out_vld_reg;
    assign result.point_x       = point_reg[0];
    assign result.point_y       = point_reg[1];
    assign result.point_z       = point_reg[2];
    assign result.result_status = status_reg;

endmodule

`default_nettype wire
